// ----- hw/rtl/fca_pkg.sv -----
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants, codes and helpers for the chain allocator block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fca_pkg;

  localparam int TABLE_BLOCKS = 128;
  localparam int MAX_FILES    = 16;

  localparam int BLK_W   = $clog2(TABLE_BLOCKS);
  localparam int FREE_W  = $clog2(TABLE_BLOCKS - 1);
  localparam int SLOT_W  = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int CNT_W   = $clog2(MAX_FILES + 1);
  localparam int ENTRY_W = 8;
  localparam int KEY_W   = 64;
  localparam int FIELD_W = 7;

  localparam logic [ENTRY_W-1:0] MARK_RESERVED = 8'hF5;
  localparam logic [ENTRY_W-1:0] MARK_END      = 8'hFF;
  localparam logic [ENTRY_W-1:0] MARK_FREE     = 8'h00;

  typedef enum logic [1:0] {
    ACT_CREATE     = 2'd0,
    ACT_INSERT     = 2'd1,
    ACT_READ_TABLE = 2'd2,
    ACT_READ_DIR   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIR_FULL  = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_BAD_LEN   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_PAST_END  = 3'd5,
    ST_BAD_INDEX = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_C_REQ,
    S_C_CHK,
    S_C_END,
    S_I_SRCH,
    S_I_REQ,
    S_I_CHK,
    S_W_REQ,
    S_W_CHK,
    S_I_WR1,
    S_I_WR2,
    S_R_REQ,
    S_R_CHK,
    S_D_OUT
  } state_t;

  // value of a table entry that has not been written since reset
  function automatic logic [ENTRY_W-1:0] reset_entry(input logic [BLK_W-1:0] idx);
    logic [ENTRY_W-1:0] v;
    if (idx == BLK_W'(0)) begin
      v = MARK_RESERVED;
    end else if (idx == BLK_W'(1)) begin
      v = MARK_END;
    end else begin
      v = MARK_FREE;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/fca_ram.sv -----
// ----------------------------------------------------------------------------
// fca_ram
// Generic single write port RAM with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fat_chain_allocator.sv -----
// ----------------------------------------------------------------------------
// fat_chain_allocator
// File allocation table of linked block chains with a small directory
// ----------------------------------------------------------------------------
// usage
//   an item is taken when start is high and busy is low; busy stays high
//   until its result is shown. each item gives one result, on the out_ ports
//   for one cycle with out_valid high; the receiver cannot hold it off.
//   create chains the lowest free blocks, insert links the lowest free block
//   into a chain after a given position, the reads return one table entry
//   or one directory slot.
// table access
//   all work runs through one table RAM port pair; each entry is read
//   through a request state and then checked in a check state.
//   a new item may be taken in the cycle its result is shown.
// reset
//   table entries read as their reset marks until first written (one valid
//   flag per entry), directory is empty, free count is table size minus two.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fat_chain_allocator (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_action,
  input  wire logic [63:0]        in_file_key,
  input  wire logic [6:0]         in_block_count,
  input  wire logic [6:0]         in_insert_position,
  input  wire logic [6:0]         in_read_index,
  output logic                    out_valid,
  output logic [2:0]              out_status,
  output logic [6:0]              out_first_block,
  output logic [3:0]              out_file_slot,
  output logic [6:0]              out_free_count,
  output logic signed [7:0]       out_entry_value,
  output logic [63:0]             out_entry_key,
  output logic [6:0]              out_file_length,
  output logic [4:0]              out_file_count
);

  localparam int BLK_W   = fca_pkg::BLK_W;
  localparam int FREE_W  = fca_pkg::FREE_W;
  localparam int SLOT_W  = fca_pkg::SLOT_W;
  localparam int CNT_W   = fca_pkg::CNT_W;
  localparam int ENTRY_W = fca_pkg::ENTRY_W;
  localparam int KEY_W   = fca_pkg::KEY_W;
  localparam int FIELD_W = fca_pkg::FIELD_W;

  fca_pkg::state_t  state_r, state_nxt;
  fca_pkg::action_t act_r;

  logic [KEY_W-1:0]   key_r;
  logic [FIELD_W-1:0] cnt_r, pos_r, idx_r;
  logic [BLK_W-1:0]   a_r, a_nxt;
  logic [BLK_W-1:0]   nb_r, nb_nxt;
  logic [BLK_W-1:0]   fb_r, fb_nxt;
  logic [FIELD_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]   slot_r, slot_nxt;
  logic [ENTRY_W-1:0] val_r, val_nxt;
  logic [FREE_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;

  logic [KEY_W-1:0]   dir_key_r   [fca_pkg::MAX_FILES];
  logic [BLK_W-1:0]   dir_first_r [fca_pkg::MAX_FILES];
  logic [FIELD_W-1:0] dir_len_r   [fca_pkg::MAX_FILES];
  logic               dir_we;
  logic [SLOT_W-1:0]  dir_widx;
  logic [KEY_W-1:0]   dir_wkey, dk;
  logic [BLK_W-1:0]   dir_wfirst, dfirst;
  logic [FIELD_W-1:0] dir_wlen, dlen;

  logic [fca_pkg::TABLE_BLOCKS-1:0] vld_r;
  logic               we;
  logic [BLK_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata, rdata, eff;
  logic               link_ok;

  logic               fin;
  fca_pkg::status_t   fin_status;
  logic [BLK_W-1:0]   fin_first;
  logic [CNT_W-1:0]   fin_slot;
  logic [FIELD_W-1:0] fin_len;
  logic [ENTRY_W-1:0] fin_value;
  logic [KEY_W-1:0]   fin_key;

  logic        out_valid_r;
  logic [2:0]  out_status_r;
  logic [6:0]  out_first_r, out_free_r, out_len_r;
  logic [3:0]  out_slot_r;
  logic [7:0]  out_value_r;
  logic [63:0] out_key_r;
  logic [4:0]  out_count_r;

  // block table
  fca_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(fca_pkg::TABLE_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(a_r),
    .rdata(rdata)
  );

  assign eff     = vld_r[a_r] ? rdata : fca_pkg::reset_entry(a_r);
  assign link_ok = ({1'b0, eff} >= 9'd2) && ({1'b0, eff} < 9'(fca_pkg::TABLE_BLOCKS));

  assign dk     = dir_key_r[slot_r[SLOT_W-1:0]];
  assign dfirst = dir_first_r[slot_r[SLOT_W-1:0]];
  assign dlen   = dir_len_r[slot_r[SLOT_W-1:0]];

  assign busy = (state_r != fca_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    a_nxt      = a_r;
    nb_nxt     = nb_r;
    fb_nxt     = fb_r;
    rem_nxt    = rem_r;
    slot_nxt   = slot_r;
    val_nxt    = val_r;
    free_nxt   = free_r;
    total_nxt  = total_r;
    we         = 1'b0;
    waddr      = nb_r;
    wdata      = fca_pkg::MARK_END;
    dir_we     = 1'b0;
    dir_widx   = slot_r[SLOT_W-1:0];
    dir_wkey   = dk;
    dir_wfirst = dfirst;
    dir_wlen   = dlen;
    fin        = 1'b0;
    fin_status = fca_pkg::ST_OK;
    fin_first  = '0;
    fin_slot   = '0;
    fin_len    = '0;
    fin_value  = '0;
    fin_key    = '0;

    case (state_r)
      fca_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = fca_pkg::S_DISP;
        end
      end

      fca_pkg::S_DISP: begin
        case (act_r)
          fca_pkg::ACT_CREATE: begin
            if (total_r >= CNT_W'(fca_pkg::MAX_FILES)) begin
              fin        = 1'b1;
              fin_status = fca_pkg::ST_DIR_FULL;
            end else if (cnt_r == '0) begin
              fin        = 1'b1;
              fin_status = fca_pkg::ST_BAD_LEN;
            end else if (8'(cnt_r) > 8'(free_r)) begin
              fin        = 1'b1;
              fin_status = fca_pkg::ST_NO_SPACE;
            end else begin
              a_nxt     = BLK_W'(2);
              rem_nxt   = cnt_r;
              state_nxt = fca_pkg::S_C_REQ;
            end
          end
          fca_pkg::ACT_INSERT: begin
            slot_nxt  = '0;
            state_nxt = fca_pkg::S_I_SRCH;
          end
          fca_pkg::ACT_READ_TABLE: begin
            if (8'(idx_r) >= 8'(fca_pkg::TABLE_BLOCKS)) begin
              fin        = 1'b1;
              fin_status = fca_pkg::ST_BAD_INDEX;
            end else begin
              a_nxt     = idx_r[BLK_W-1:0];
              state_nxt = fca_pkg::S_R_REQ;
            end
          end
          fca_pkg::ACT_READ_DIR: begin
            if (8'(idx_r) >= 8'(total_r) || 8'(idx_r) >= 8'(fca_pkg::MAX_FILES)) begin
              fin        = 1'b1;
              fin_status = fca_pkg::ST_BAD_INDEX;
            end else begin
              slot_nxt  = CNT_W'(idx_r);
              state_nxt = fca_pkg::S_D_OUT;
            end
          end
          default: begin
            state_nxt = fca_pkg::S_IDLE;
          end
        endcase
      end

      fca_pkg::S_C_REQ: begin
        state_nxt = fca_pkg::S_C_CHK;
      end

      fca_pkg::S_C_CHK: begin
        if (eff == fca_pkg::MARK_FREE) begin
          if (rem_r == cnt_r) begin
            fb_nxt = a_r;
          end else begin
            we    = 1'b1;
            waddr = nb_r;
            wdata = ENTRY_W'(a_r);
          end
          nb_nxt  = a_r;
          rem_nxt = rem_r - FIELD_W'(1);
          if (rem_r == FIELD_W'(1)) begin
            state_nxt = fca_pkg::S_C_END;
          end else begin
            a_nxt     = a_r + BLK_W'(1);
            state_nxt = fca_pkg::S_C_REQ;
          end
        end else begin
          a_nxt     = a_r + BLK_W'(1);
          state_nxt = fca_pkg::S_C_REQ;
        end
      end

      fca_pkg::S_C_END: begin
        we         = 1'b1;
        waddr      = nb_r;
        wdata      = fca_pkg::MARK_END;
        dir_we     = 1'b1;
        dir_widx   = total_r[SLOT_W-1:0];
        dir_wkey   = key_r;
        dir_wfirst = fb_r;
        dir_wlen   = cnt_r;
        free_nxt   = free_r - FREE_W'(cnt_r);
        total_nxt  = total_r + CNT_W'(1);
        fin        = 1'b1;
        fin_first  = fb_r;
        fin_slot   = total_r;
        fin_len    = cnt_r;
      end

      fca_pkg::S_I_SRCH: begin
        if (slot_r >= total_r) begin
          fin        = 1'b1;
          fin_status = fca_pkg::ST_NOT_FOUND;
        end else if (dk == key_r) begin
          if (pos_r > dlen) begin
            fin        = 1'b1;
            fin_status = fca_pkg::ST_PAST_END;
          end else if (free_r == '0) begin
            fin        = 1'b1;
            fin_status = fca_pkg::ST_NO_SPACE;
          end else begin
            a_nxt     = BLK_W'(2);
            state_nxt = fca_pkg::S_I_REQ;
          end
        end else begin
          slot_nxt = slot_r + CNT_W'(1);
        end
      end

      fca_pkg::S_I_REQ: begin
        state_nxt = fca_pkg::S_I_CHK;
      end

      fca_pkg::S_I_CHK: begin
        if (eff == fca_pkg::MARK_FREE) begin
          nb_nxt    = a_r;
          a_nxt     = dfirst;
          rem_nxt   = (pos_r > FIELD_W'(1)) ? pos_r - FIELD_W'(1) : '0;
          state_nxt = fca_pkg::S_W_REQ;
        end else begin
          a_nxt     = a_r + BLK_W'(1);
          state_nxt = fca_pkg::S_I_REQ;
        end
      end

      fca_pkg::S_W_REQ: begin
        state_nxt = fca_pkg::S_W_CHK;
      end

      fca_pkg::S_W_CHK: begin
        if (rem_r == '0 || !link_ok) begin
          val_nxt   = eff;
          state_nxt = fca_pkg::S_I_WR1;
        end else begin
          a_nxt     = eff[BLK_W-1:0];
          rem_nxt   = rem_r - FIELD_W'(1);
          state_nxt = fca_pkg::S_W_REQ;
        end
      end

      fca_pkg::S_I_WR1: begin
        we        = 1'b1;
        waddr     = nb_r;
        wdata     = val_r;
        state_nxt = fca_pkg::S_I_WR2;
      end

      fca_pkg::S_I_WR2: begin
        we        = 1'b1;
        waddr     = a_r;
        wdata     = ENTRY_W'(nb_r);
        dir_we    = 1'b1;
        dir_wlen  = dlen + FIELD_W'(1);
        free_nxt  = free_r - FREE_W'(1);
        fin       = 1'b1;
        fin_first = dfirst;
        fin_slot  = slot_r;
        fin_len   = dlen + FIELD_W'(1);
      end

      fca_pkg::S_R_REQ: begin
        state_nxt = fca_pkg::S_R_CHK;
      end

      fca_pkg::S_R_CHK: begin
        fin       = 1'b1;
        fin_value = eff;
      end

      fca_pkg::S_D_OUT: begin
        fin       = 1'b1;
        fin_key   = dk;
        fin_first = dfirst;
        fin_len   = dlen;
        fin_slot  = slot_r;
      end

      default: begin
        state_nxt = fca_pkg::S_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = fca_pkg::S_IDLE;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fca_pkg::S_IDLE;
      free_r      <= FREE_W'(fca_pkg::TABLE_BLOCKS - 2);
      total_r     <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      out_valid_r <= fin;
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
    end
  end

  // datapath and result registers
  always_ff @(posedge clk) begin
    if (state_r == fca_pkg::S_IDLE && start) begin
      act_r <= fca_pkg::action_t'(in_action);
      key_r <= in_file_key;
      cnt_r <= in_block_count;
      pos_r <= in_insert_position;
      idx_r <= in_read_index;
    end
    a_r    <= a_nxt;
    nb_r   <= nb_nxt;
    fb_r   <= fb_nxt;
    rem_r  <= rem_nxt;
    slot_r <= slot_nxt;
    val_r  <= val_nxt;
    if (dir_we) begin
      dir_key_r[dir_widx]   <= dir_wkey;
      dir_first_r[dir_widx] <= dir_wfirst;
      dir_len_r[dir_widx]   <= dir_wlen;
    end
    if (fin) begin
      out_status_r <= fin_status;
      out_first_r  <= 7'(fin_first);
      out_slot_r   <= 4'(fin_slot);
      out_free_r   <= 7'(free_nxt);
      out_value_r  <= fin_value;
      out_key_r    <= fin_key;
      out_len_r    <= 7'(fin_len);
      out_count_r  <= 5'(total_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_first_block = out_first_r;
  assign out_file_slot   = out_slot_r;
  assign out_free_count  = out_free_r;
  assign out_entry_value = out_value_r;
  assign out_entry_key   = out_key_r;
  assign out_file_length = out_len_r;
  assign out_file_count  = out_count_r;

endmodule

`default_nettype wire

// ----- hw/rtl/fca_checker.sv -----
// ----------------------------------------------------------------------------
// fca_checker
// Port level checks for the chain allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fca_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [2:0]  out_status,
  input wire logic [6:0]  out_first_block,
  input wire logic [6:0]  out_free_count,
  input wire logic [63:0] out_entry_key,
  input wire logic [6:0]  out_file_length,
  input wire logic [4:0]  out_file_count
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // results come one at a time, never in back to back cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // failed items carry no file information
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != fca_pkg::ST_OK) |->
      (out_first_block == '0 && out_file_length == '0 && out_entry_key == '0))
    else $error("failed item carries file fields");

  a_counts_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_file_count <= 5'(fca_pkg::MAX_FILES)
                   && out_free_count <= 7'(fca_pkg::TABLE_BLOCKS - 2)))
    else $error("free or file count out of range");

endmodule

bind fat_chain_allocator fca_checker u_fca_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_first_block(out_first_block),
  .out_free_count (out_free_count),
  .out_entry_key  (out_entry_key),
  .out_file_length(out_file_length),
  .out_file_count (out_file_count)
);

`default_nettype wire
